// ===== rtl/smd_pkg.sv =====
// Shared types and constants of the scaled multiply-divide pipeline.
// No dependencies.
package smd_pkg;

   localparam logic [2:0] OP_SIGNED     = 3'd0;
   localparam logic [2:0] OP_UNSIGNED   = 3'd1;
   localparam logic [2:0] OP_SIGNED_RND = 3'd2;
   localparam logic [2:0] OP_UNSIGN_RND = 3'd3;
   localparam logic [2:0] OP_WIDE       = 3'd4;

   localparam int NUM_W      = 96;
   localparam int DIV_W      = 32;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = NUM_W / DIV_BITS;

   // control that travels with each item
   typedef struct packed {
      logic sgn_op;   // ops 0 and 2
      logic wide;     // op 4
      logic neg_a;    // factor signs xor (for signed ops)
      logic neg_c;    // divisor sign (for signed ops)
      logic prod_nz;  // biased product is nonzero
      logic dz;       // divisor was zero
      logic kill;     // unused op code, result zero
   } ctl_type;

endpackage

// ===== rtl/scaled_multiply_divide.sv =====
// Top level of the scaled multiply-divide unit: a*b/c with a 96-bit intermediate.
// Depends on smd_pkg and smd_div_pipe.
//
// One item is accepted every cycle while the pipeline is not held; it passes through
// one prepare stage, one multiply stage (two 32x32 products), one stage that
// sums the products and rounding bias, 24 divider stages of 4 quotient bits
// each, and the output register that applies sign and zero-divisor rules.
// The whole pipeline holds while a result waits under rsp_stall.
module scaled_multiply_divide (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_value_a,
   input  logic [31:0] req_multiplier,
   input  logic [31:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_quotient,
   output logic        rsp_divide_by_zero
);
   import smd_pkg::*;

   logic en;

   // advance everything unless the result register is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // prepare: magnitudes, bias and control
   logic        v1_ff;
   logic [31:0] xl1_ff, xh1_ff, y1_ff, d1_ff;
   logic [30:0] b1_ff;
   ctl_type     c1_ff;
   logic [31:0] xl1_in, xh1_in, y1_in, d1_in;
   logic [30:0] b1_in;
   ctl_type     c1_in;

   always_comb begin
      logic na, nb, nc, sg;
      sg = (req_op == OP_SIGNED) || (req_op == OP_SIGNED_RND);
      na = sg && req_value_a[31];
      nb = sg && req_multiplier[31];
      nc = sg && req_divisor[31];
      xl1_in = na ? (32'd0 - req_value_a[31:0]) : req_value_a[31:0];
      xh1_in = (req_op == OP_WIDE) ? req_value_a[63:32] : 32'd0;
      y1_in  = nb ? (32'd0 - req_multiplier) : req_multiplier;
      d1_in  = nc ? (32'd0 - req_divisor) : req_divisor;
      b1_in  = ((req_op == OP_SIGNED_RND) || (req_op == OP_UNSIGN_RND)) ?
               d1_in[31:1] : 31'd0;
      c1_in.sgn_op  = sg;
      c1_in.wide    = (req_op == OP_WIDE);
      c1_in.neg_a   = na ^ nb;
      c1_in.neg_c   = nc;
      c1_in.prod_nz = 1'b0;
      c1_in.dz      = (req_op <= OP_WIDE) && (req_divisor == 32'd0);
      c1_in.kill    = (req_op > OP_WIDE);
   end

   // multiply: two partial products
   logic        v2_ff;
   logic [63:0] pl2_ff, ph2_ff;
   logic [30:0] b2_ff;
   logic [31:0] d2_ff;
   ctl_type     c2_ff;

   // sum products and bias into the dividend
   logic        v3_ff;
   logic [95:0] n3_ff, n3_in;
   logic [31:0] d3_ff;
   ctl_type     c3_ff, c3_in;

   always_comb begin
      n3_in = {32'd0, pl2_ff} + {ph2_ff, 32'd0} + {65'd0, b2_ff};
      c3_in = c2_ff;
      c3_in.prod_nz = (n3_in != 96'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         xl1_ff <= xl1_in;
         xh1_ff <= xh1_in;
         y1_ff  <= y1_in;
         d1_ff  <= d1_in;
         b1_ff  <= b1_in;
         c1_ff  <= c1_in;
         pl2_ff <= {32'd0, xl1_ff} * {32'd0, y1_ff};
         ph2_ff <= {32'd0, xh1_ff} * {32'd0, y1_ff};
         b2_ff  <= b1_ff;
         d2_ff  <= d1_ff;
         c2_ff  <= c1_ff;
         n3_ff  <= n3_in;
         d3_ff  <= d2_ff;
         c3_ff  <= c3_in;
      end
   end

   logic        vq;
   logic [95:0] quot;
   ctl_type     cq;

   smd_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_num    (n3_ff),
      .in_div    (d3_ff),
      .in_ctl    (c3_ff),
      .out_valid (vq),
      .out_quot  (quot),
      .out_ctl   (cq)
   );

   // output register: sign, width, zero-divisor and unused-op rules
   logic        rv_ff;
   logic [63:0] rq_ff, rq_in;
   logic        rdz_ff;
   logic        rwide_ff;

   always_comb begin
      logic        neg;
      logic [31:0] q32;
      neg = (cq.neg_a && cq.prod_nz) ? !cq.neg_c : cq.neg_c;
      q32 = (cq.sgn_op && neg) ? (32'd0 - quot[31:0]) : quot[31:0];
      if (cq.dz || cq.kill) begin
         rq_in = 64'd0;
      end else if (cq.wide) begin
         rq_in = quot[63:0];
      end else begin
         rq_in = {32'd0, q32};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= vq;
      end
      if (en) begin
         rq_ff    <= rq_in;
         rdz_ff   <= cq.dz;
         rwide_ff <= cq.wide;
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_quotient       = rq_ff;
   assign rsp_divide_by_zero = rdz_ff;

`ifndef ASSERT_OFF
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_quotient == 64'd0)
      else $error("zero divisor result not zero");
   a_narrow_upper: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rwide_ff |-> rsp_quotient[63:32] == 32'd0)
      else $error("narrow op has upper quotient bits set");
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input held without a held result");
   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vq) && $stable(v3_ff))
      else $error("pipeline moved while held");
`endif

endmodule

// ===== rtl/smd_div_pipe.sv =====
// Pipelined restoring divider: 96-bit dividend by 32-bit divisor,
// DIV_BITS quotient bits per stage. Depends on smd_pkg.
module smd_div_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [smd_pkg::NUM_W-1:0]  in_num,
   input  logic [smd_pkg::DIV_W-1:0]  in_div,
   input  smd_pkg::ctl_type           in_ctl,
   output logic                       out_valid,
   output logic [smd_pkg::NUM_W-1:0]  out_quot,
   output smd_pkg::ctl_type           out_ctl
);
   import smd_pkg::*;

   logic [DIV_STAGES-1:0] v_ff;
   logic [DIV_W-1:0]      rem_ff [DIV_STAGES];
   logic [NUM_W-1:0]      num_ff [DIV_STAGES];
   logic [DIV_W-1:0]      d_ff   [DIV_STAGES];
   ctl_type               ctl_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [DIV_W-1:0] rem_src;
      logic [NUM_W-1:0] num_src;
      logic [DIV_W-1:0] d_src;
      ctl_type          ctl_src;
      logic             v_src;
      logic [DIV_W-1:0] rem_in;
      logic [NUM_W-1:0] num_in;

      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = in_num;
         assign d_src   = in_div;
         assign ctl_src = in_ctl;
         assign v_src   = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign num_src = num_ff[s-1];
         assign d_src   = d_ff[s-1];
         assign ctl_src = ctl_ff[s-1];
         assign v_src   = v_ff[s-1];
      end

      // DIV_BITS times: shift in one dividend bit, subtract when it fits, shift in the quotient bit
      always_comb begin
         logic [DIV_W:0] trial;
         rem_in = rem_src;
         num_in = num_src;
         for (int k = 0; k < DIV_BITS; k++) begin
            trial = {rem_in, num_in[NUM_W-1]};
            num_in = {num_in[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, d_src}) begin
               trial = trial - {1'b0, d_src};
               num_in[0] = 1'b1;
            end
            rem_in = trial[DIV_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_src;
         end
         if (en) begin
            rem_ff[s] <= rem_in;
            num_ff[s] <= num_in;
            d_ff[s]   <= d_src;
            ctl_ff[s] <= ctl_src;
         end
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_quot  = num_ff[DIV_STAGES-1];
   assign out_ctl   = ctl_ff[DIV_STAGES-1];

endmodule
